// ===== rtl/refcounted_device_handle_table_assert.svh =====
// Assertion helpers for the handle table.
// In simulation they expand to concurrent assertions. With SYNTH defined they expand to nothing.
`ifndef REFCOUNTED_DEVICE_HANDLE_TABLE_ASSERT_SVH
`define REFCOUNTED_DEVICE_HANDLE_TABLE_ASSERT_SVH

`ifndef SYNTH

// Property that holds at every clock edge outside reset.
`define RDHT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rdht: property failed");

// When pre holds, post holds in the next cycle.
`define RDHT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rdht: next-cycle property failed");

`else

`define RDHT_ASSERT(label, clk, rst_n, prop)
`define RDHT_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/rdht_pkg.sv =====
package rdht_pkg;

    // Default configuration of the table
    localparam int DEF_TABLE_ENTRIES = 128;
    localparam int DEF_TYPE_COUNT    = 16;
    localparam int DEF_UNIT_BITS     = 8;
    localparam int DEF_COUNT_BITS    = 8;

    // Field widths on the ports
    localparam int MASK_W   = 16;
    localparam int TYPE_W   = 4;
    localparam int UNIT_W   = 8;
    localparam int HANDLE_W = 7;
    localparam int REFCNT_W = 8;
    localparam int STATUS_W = 3;

    // Request kinds
    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OPEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

    // One result, as handed from the controller to the output stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle_out;
        logic [REFCNT_W-1:0] ref_count;
        logic                created;
        logic                released;
    } res_t;

endpackage

// ===== rtl/refcounted_device_handle_table.sv =====
// Reference-counted device handle table.
// Requests enter on the s_ side: s_tuser is the kind (0 open, 1 close), s_tdata carries
// dev_type, unit and handle_in. Every request yields exactly one result transaction on
// the m_ side: status, handle_out, ref_count, created and released.
// type_present_mask is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the table is idle, which the block does not enforce. An open makes one linear pass
// over the table memory, one read per cycle, looking for a match and the lowest free entry
// at once, then updates the matching or free entry; a close reads the entry and writes it
// back; an unknown type or an out-of-range close goes straight to the result. The next
// request is taken in the cycle after the result leaves the controller, one at a time.
// After reset a clearing pass over all TABLE_ENTRIES entries zeroes all counts; s_tready stays
// low until it is done. Config writes are taken at any time.
// The result sits in an output register; while the receiver stalls the controller still
// accepts and works on the next request and holds its result until the register frees up.
module refcounted_device_handle_table
    import rdht_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int TYPE_COUNT    = DEF_TYPE_COUNT,
    parameter int UNIT_BITS     = DEF_UNIT_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration: type_present_mask
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    // requests
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // dev_type[3:0], unit[11:4], handle_in[18:12], zero
    input  logic              s_tuser,   // kind
    // results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata    // status[2:0], handle_out[9:3], ref_count[17:10],
                                         // created[18], released[19], zero
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = COUNT_BITS + TYPE_W + UNIT_BITS;

    logic [MASK_W-1:0]  mask_reg;
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;

    logic               res_vld;
    logic               res_rdy;
    res_t               res;

    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    // type registration mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mask_reg <= cfg_wr_data;
        end
    end

    rdht_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TYPE_COUNT    (TYPE_COUNT),
        .UNIT_BITS     (UNIT_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_dev_type (s_tdata[3:0]),
        .in_unit     (s_tdata[11:4]),
        .in_handle   (s_tdata[18:12]),
        .type_mask   (mask_reg),
        .res_vld     (res_vld),
        .res_rdy     (res_rdy),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // entry word: count on top, then type, unit in the low bits
    rdht_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // output register: loads when empty or being drained this cycle
    assign res_rdy = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else if (res_vld && res_rdy)
        begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {4'b0, res.released, res.created, res.ref_count,
                             res.handle_out, res.status};
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/rdht_mem.sv =====
module rdht_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 20
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/rdht_ctrl.sv =====
`include "refcounted_device_handle_table_assert.svh"

module rdht_ctrl
    import rdht_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int TYPE_COUNT    = DEF_TYPE_COUNT,
    parameter int UNIT_BITS     = DEF_UNIT_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    // request side
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic                                            in_kind,
    input  logic [TYPE_W-1:0]                               in_dev_type,
    input  logic [UNIT_W-1:0]                               in_unit,
    input  logic [HANDLE_W-1:0]                             in_handle,
    input  logic [MASK_W-1:0]                               type_mask,
    // result side
    output logic                                            res_vld,
    input  logic                                            res_rdy,
    output res_t                                            res,
    // table memory
    output logic                                            mem_rd_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]                mem_rd_addr,
    input  logic [COUNT_BITS+TYPE_W+UNIT_BITS-1:0]          mem_rd_data,
    output logic                                            mem_wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]                mem_wr_addr,
    output logic [COUNT_BITS+TYPE_W+UNIT_BITS-1:0]          mem_wr_data
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = COUNT_BITS + TYPE_W + UNIT_BITS;
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CL_RD,
        S_CL_WR,
        S_RESULT
    } state_t;

    state_t                state_reg,      state_next;
    logic [IDX_W-1:0]      idx_reg,        idx_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  chk_vld_reg,    chk_vld_next;
    logic [IDX_W-1:0]      chk_idx_reg,    chk_idx_next;
    logic [TYPE_W-1:0]     type_reg,       type_next;
    logic [UNIT_BITS-1:0]  unit_reg,       unit_next;
    logic [HANDLE_W-1:0]   handle_reg,     handle_next;
    logic                  match_vld_reg,  match_vld_next;
    logic [IDX_W-1:0]      match_idx_reg,  match_idx_next;
    logic [COUNT_BITS-1:0] match_cnt_reg,  match_cnt_next;
    logic                  free_vld_reg,   free_vld_next;
    logic [IDX_W-1:0]      free_idx_reg,   free_idx_next;
    res_t                  res_reg,        res_next;

    // fields of the entry read last cycle
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [TYPE_W-1:0]     rd_type;
    logic [UNIT_BITS-1:0]  rd_unit;
    logic                  type_ok;
    logic                  handle_ok;

    assign rd_cnt  = mem_rd_data[ENTRY_W-1 -: COUNT_BITS];
    assign rd_type = mem_rd_data[UNIT_BITS +: TYPE_W];
    assign rd_unit = mem_rd_data[UNIT_BITS-1:0];

    assign type_ok   = (32'(in_dev_type) < TYPE_COUNT) && type_mask[in_dev_type];
    assign handle_ok = 32'(in_handle) < TABLE_ENTRIES;

    assign in_ready = (state_reg == S_IDLE);
    assign res_vld  = (state_reg == S_RESULT);
    assign res      = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        type_next       = type_reg;
        unit_next       = unit_reg;
        handle_next     = handle_reg;
        match_vld_next  = match_vld_reg;
        match_idx_next  = match_idx_reg;
        match_cnt_next  = match_cnt_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        res_next        = res_reg;

        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero count marks the entry free
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg;
                mem_wr_data = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    type_next   = in_dev_type;
                    unit_next   = UNIT_BITS'(in_unit);
                    handle_next = in_handle;
                    if (in_kind == KIND_OPEN)
                    begin
                        if (type_ok)
                        begin
                            idx_next        = '0;
                            issue_done_next = 1'b0;
                            match_vld_next  = 1'b0;
                            free_vld_next   = 1'b0;
                            state_next      = S_SCAN;
                        end
                        else
                        begin
                            res_next   = '{ST_UNKNOWN, '0, '0, 1'b0, 1'b0};
                            state_next = S_RESULT;
                        end
                    end
                    else if (handle_ok)
                    begin
                        state_next = S_CL_RD;
                    end
                    else
                    begin
                        res_next   = '{ST_NOT_OPEN, in_handle, '0, 1'b0, 1'b0};
                        state_next = S_RESULT;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle; check the entry returned in the next cycle
                if (!issue_done_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                chk_vld_next = !issue_done_reg;
                chk_idx_next = idx_reg;

                if (chk_vld_reg)
                begin
                    if (rd_cnt != '0 && rd_type == type_reg && rd_unit == unit_reg &&
                        !match_vld_reg)
                    begin
                        match_vld_next = 1'b1;
                        match_idx_next = chk_idx_reg;
                        match_cnt_next = rd_cnt;
                    end
                    if (rd_cnt == '0 && !free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                state_next = S_RESULT;
                if (match_vld_reg)
                begin
                    if (match_cnt_reg == COUNT_MAX)
                    begin
                        res_next = '{ST_SATURATED, HANDLE_W'(match_idx_reg),
                                     REFCNT_W'(match_cnt_reg), 1'b0, 1'b0};
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = match_idx_reg;
                        mem_wr_data = {match_cnt_reg + 1'b1, type_reg, unit_reg};
                        res_next    = '{ST_OK, HANDLE_W'(match_idx_reg),
                                        REFCNT_W'(match_cnt_reg + 1'b1), 1'b0, 1'b0};
                    end
                end
                else if (free_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = free_idx_reg;
                    mem_wr_data = {COUNT_BITS'(1), type_reg, unit_reg};
                    res_next    = '{ST_OK, HANDLE_W'(free_idx_reg), REFCNT_W'(1), 1'b1, 1'b0};
                end
                else
                begin
                    res_next = '{ST_FULL, '0, '0, 1'b0, 1'b0};
                end
            end

            S_CL_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = IDX_W'(handle_reg);
                state_next  = S_CL_WR;
            end

            S_CL_WR:
            begin
                state_next = S_RESULT;
                if (rd_cnt == '0)
                begin
                    res_next = '{ST_NOT_OPEN, handle_reg, '0, 1'b0, 1'b0};
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IDX_W'(handle_reg);
                    mem_wr_data = {rd_cnt - 1'b1, rd_type, rd_unit};
                    res_next    = '{ST_OK, handle_reg, REFCNT_W'(rd_cnt - 1'b1), 1'b0,
                                    (rd_cnt == COUNT_BITS'(1))};
                end
            end

            S_RESULT:
            begin
                if (res_rdy)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            type_reg       <= '0;
            unit_reg       <= '0;
            handle_reg     <= '0;
            match_vld_reg  <= 1'b0;
            match_idx_reg  <= '0;
            match_cnt_reg  <= '0;
            free_vld_reg   <= 1'b0;
            free_idx_reg   <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            type_reg       <= type_next;
            unit_reg       <= unit_next;
            handle_reg     <= handle_next;
            match_vld_reg  <= match_vld_next;
            match_idx_reg  <= match_idx_next;
            match_cnt_reg  <= match_cnt_next;
            free_vld_reg   <= free_vld_next;
            free_idx_reg   <= free_idx_next;
            res_reg        <= res_next;
        end
    end

    // an accepted request leaves the controller busy in the next cycle
    `RDHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, (in_valid && in_ready), !in_ready)
    // every scan read is checked in the following cycle
    `RDHT_ASSERT_NEXT(a_scan_check, clk, rst_n, (state_reg == S_SCAN && mem_rd_en), chk_vld_reg)
    `RDHT_ASSERT(a_status_code, clk, rst_n, res_vld |-> (res_reg.status <= ST_SATURATED))
    `RDHT_ASSERT(a_created_one, clk, rst_n, (res_vld && res_reg.created) |-> (res_reg.status == ST_OK && res_reg.ref_count == REFCNT_W'(1)))
    `RDHT_ASSERT(a_released_zero, clk, rst_n, (res_vld && res_reg.released) |-> (res_reg.status == ST_OK && res_reg.ref_count == '0))

endmodule
